@@ rtl/srir_pkg.sv @@
package srir_pkg;

  localparam logic [2:0] MODE_LINE   = 3'd0;
  localparam logic [2:0] MODE_READ   = 3'd1;
  localparam logic [2:0] MODE_WRITE  = 3'd2;
  localparam logic [2:0] MODE_STATUS = 3'd3;
  localparam logic [2:0] MODE_ACK    = 3'd4;

  localparam int SRE_BIT  = 10;
  localparam int TOS_LSB  = 11;
  localparam int SRR_BIT  = 24;
  localparam int CLRR_BIT = 25;
  localparam int SETR_BIT = 26;
  localparam int IOV_BIT  = 27;

  localparam logic [13:0] MODULE_ID_OFFSET = 14'h0008;
  localparam logic [13:0] STATUS_BASE      = 14'h0200;
  localparam logic [13:0] STATUS_END       = 14'h0280;
  localparam logic [3:0]  SUB_STATUS       = 4'h0;
  localparam logic [3:0]  SUB_ACK          = 4'h4;
  localparam logic [31:0] MODULE_ID        = 32'h00B9_C013;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  source_index;
    logic        line_level;
    logic [13:0] bus_offset;
    logic [31:0] write_data;
    logic [2:0]  target_index;
  } srir_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [7:0]  target_lines;
  } srir_rsp_t;

endpackage

@@ rtl/service_request_interrupt_router_unit.sv @@
// Service request interrupt router.
// Request channel: drive request and raise start; the request is taken at a
// rising edge where start is high and busy is low. Busy stays high until the
// result has been shown.
// Result channel: done is high for exactly one cycle with result valid; the
// receiver cannot stall, so the result must be taken in that cycle.
// Path from accept to done:
//   status read, unknown mode or source out of range: straight to ST_FINISH
//   source read: ST_FETCH, ST_MODIFY, then ST_FINISH
//   line event, source write, acknowledge: ST_FETCH, ST_MODIFY, then ST_SCAN,
//   a rescan of every source word through the single read port of the source
//   memory, one word per cycle, then ST_FINISH.
// A new request is taken only after done, once busy has dropped.
// Reset (synchronous, rst high) starts a clearing pass that writes zero to
// each source word, one per cycle; busy is high during the pass. Target
// status and the acknowledge capture clear at once.
module service_request_interrupt_router_unit #(
  parameter int NUM_SOURCES = 256,
  parameter int NUM_TARGETS = 8
) (
  input  srir_pkg::srir_req_t request,
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  output srir_pkg::srir_rsp_t result
);

  localparam int SW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int TW = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_FETCH  = 6'b000100,
    ST_MODIFY = 6'b001000,
    ST_SCAN   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t              state;
  srir_pkg::srir_req_t req;
  logic [SW:0]         cnt;
  logic [SW-1:0]       idx;
  logic [SW-1:0]       scan_idx;
  logic                scan_vld;
  logic [31:0]         rd_word;
  logic [31:0]         last_ack;

  logic [NUM_TARGETS-1:0] found;
  logic [7:0]             best_pri [NUM_TARGETS];
  logic [10:0]            best_id  [NUM_TARGETS];

  logic [31:0] mem [NUM_SOURCES];
  logic [31:0] mem_q;
  logic        mem_we;
  logic [SW-1:0] mem_waddr;
  logic [SW-1:0] mem_raddr;
  logic [31:0] mem_wdata;

  logic [11:0] in_idx;
  logic        in_range;
  logic        in_rearb;
  logic        in_read;
  logic [2:0]  sel_t;
  logic [31:0] sel_status;
  logic [31:0] status_rd;
  logic [31:0] new_word;
  logic [2:0]  w_tos;
  logic [TW-1:0] w_t;
  logic        w_hit;

  always_comb begin
    if (request.mode == srir_pkg::MODE_LINE || request.mode == srir_pkg::MODE_ACK) begin
      in_idx = {4'd0, request.source_index};
    end else begin
      in_idx = request.bus_offset[13:2];
    end
    in_range = {20'd0, in_idx} < 32'(NUM_SOURCES);
    in_rearb = in_range && (request.mode == srir_pkg::MODE_LINE ||
                            request.mode == srir_pkg::MODE_WRITE ||
                            request.mode == srir_pkg::MODE_ACK);
    in_read  = in_range && request.mode == srir_pkg::MODE_READ;
  end

  always_comb begin
    sel_t = (state == ST_IDLE) ? request.bus_offset[6:4] : req.target_index;
    sel_status = '0;
    if ({29'd0, sel_t} < 32'(NUM_TARGETS)) begin
      if (found[sel_t[TW-1:0]]) begin
        sel_status = {2'b11, 3'b000, best_id[sel_t[TW-1:0]], 8'd0,
                      best_pri[sel_t[TW-1:0]]};
      end
    end
  end

  always_comb begin
    status_rd = '0;
    if (request.bus_offset == srir_pkg::MODULE_ID_OFFSET) begin
      status_rd = srir_pkg::MODULE_ID;
    end else if (request.bus_offset >= srir_pkg::STATUS_BASE &&
                 request.bus_offset < srir_pkg::STATUS_END) begin
      if (request.bus_offset[3:0] == srir_pkg::SUB_STATUS) begin
        status_rd = sel_status;
      end else if (request.bus_offset[3:0] == srir_pkg::SUB_ACK) begin
        status_rd = last_ack;
      end
    end
  end

  always_comb begin
    new_word = mem_q;
    unique case (req.mode)
      srir_pkg::MODE_LINE: begin
        if (req.line_level) begin
          if (mem_q[srir_pkg::SRR_BIT]) begin
            new_word[srir_pkg::IOV_BIT] = 1'b1;
          end
          new_word[srir_pkg::SRR_BIT] = 1'b1;
        end
      end
      srir_pkg::MODE_WRITE: begin
        new_word = req.write_data;
        new_word[srir_pkg::SETR_BIT] = 1'b0;
        new_word[srir_pkg::CLRR_BIT] = 1'b0;
        if (req.write_data[srir_pkg::SETR_BIT] && !req.write_data[srir_pkg::CLRR_BIT]) begin
          new_word[srir_pkg::SRR_BIT] = 1'b1;
        end else if (req.write_data[srir_pkg::CLRR_BIT] &&
                     !req.write_data[srir_pkg::SETR_BIT]) begin
          new_word[srir_pkg::SRR_BIT] = 1'b0;
        end
      end
      srir_pkg::MODE_ACK: begin
        new_word[srir_pkg::SRR_BIT] = 1'b0;
      end
      default: begin
        new_word = mem_q;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = new_word;
    mem_raddr = idx;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[SW-1:0];
        mem_wdata = '0;
      end
      ST_MODIFY: begin
        mem_we = req.mode != srir_pkg::MODE_READ;
      end
      ST_SCAN: begin
        mem_raddr = cnt[SW-1:0];
      end
      ST_IDLE, ST_FETCH, ST_FINISH: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  always_comb begin
    w_tos = mem_q[srir_pkg::TOS_LSB +: 3];
    w_t   = w_tos[TW-1:0];
    w_hit = scan_vld && mem_q[srir_pkg::SRR_BIT] && mem_q[srir_pkg::SRE_BIT] &&
            ({29'd0, w_tos} < 32'(NUM_TARGETS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cnt      <= '0;
      scan_vld <= 1'b0;
      found    <= '0;
      last_ack <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (cnt == (SW+1)'(NUM_SOURCES - 1)) begin
            state <= ST_IDLE;
          end
          cnt <= cnt + 1'b1;
        end
        ST_IDLE: begin
          if (start) begin
            req     <= request;
            idx     <= in_idx[SW-1:0];
            if (in_rearb || in_read) begin
              rd_word <= '0;
              state   <= ST_FETCH;
            end else begin
              if (request.mode == srir_pkg::MODE_STATUS) begin
                rd_word <= status_rd;
              end else begin
                rd_word <= '0;
              end
              state <= ST_FINISH;
            end
          end
        end
        ST_FETCH: begin
          state <= ST_MODIFY;
        end
        ST_MODIFY: begin
          if (req.mode == srir_pkg::MODE_READ) begin
            rd_word <= mem_q;
            state   <= ST_FINISH;
          end else begin
            if (req.mode == srir_pkg::MODE_ACK) begin
              last_ack <= sel_status | 32'h2000_0000;
            end
            found <= '0;
            cnt   <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt == (SW+1)'(NUM_SOURCES)) begin
            scan_vld <= 1'b0;
            state    <= ST_FINISH;
          end else begin
            scan_vld <= 1'b1;
            scan_idx <= cnt[SW-1:0];
            cnt      <= cnt + 1'b1;
          end
        end
        ST_FINISH: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (w_hit) begin
        if (!found[w_t] || mem_q[7:0] >= best_pri[w_t]) begin
          found[w_t]    <= 1'b1;
          best_pri[w_t] <= mem_q[7:0];
          best_id[w_t]  <= 11'(scan_idx);
        end
      end
    end
  end

  assign busy                = state != ST_IDLE;
  assign done                = state == ST_FINISH;
  assign result.read_data    = rd_word;
  assign result.target_lines = 8'(found);

endmodule

@@ bench/srir_checker.sv @@
module srir_checker #(
  parameter int NUM_SOURCES = 256,
  parameter int NUM_TARGETS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  srir_pkg::srir_req_t request,
  input  logic                done,
  input  srir_pkg::srir_rsp_t result,
  output int                  failures,
  output int                  outstanding
);

  localparam int ID_LSB    = 16;
  localparam int ENTER_BIT = 29;
  localparam int STAT_BIT  = 30;
  localparam int VALID_BIT = 31;

  logic [31:0] source_word [NUM_SOURCES];
  logic [31:0] target_word [8];
  logic [31:0] ack_capture;
  logic [7:0]  line_mask;
  srir_pkg::srir_rsp_t expected_rsp [$];

  initial begin
    failures = 0;
    outstanding = 0;
  end

  function automatic void rank_targets();
    logic        found [8];
    logic [7:0]  best_pri [8];
    logic [10:0] best_id [8];
    logic [31:0] w;
    logic [2:0]  tos;
    for (int t = 0; t < 8; t++) begin
      found[t] = 1'b0;
      best_pri[t] = '0;
      best_id[t] = '0;
    end
    for (int n = 0; n < NUM_SOURCES; n++) begin
      w = source_word[n];
      tos = w[srir_pkg::TOS_LSB +: 3];
      if (w[srir_pkg::SRR_BIT] && w[srir_pkg::SRE_BIT] && tos < NUM_TARGETS) begin
        if (!found[tos] || w[7:0] >= best_pri[tos]) begin
          found[tos] = 1'b1;
          best_pri[tos] = w[7:0];
          best_id[tos] = 11'(n);
        end
      end
    end
    line_mask = '0;
    for (int t = 0; t < 8; t++) begin
      target_word[t] = '0;
      if (t < NUM_TARGETS && found[t]) begin
        target_word[t][VALID_BIT] = 1'b1;
        target_word[t][STAT_BIT] = 1'b1;
        target_word[t][ID_LSB +: 11] = best_id[t];
        target_word[t][7:0] = best_pri[t];
        line_mask[t] = 1'b1;
      end
    end
  endfunction

  function automatic srir_pkg::srir_rsp_t serve(input srir_pkg::srir_req_t r);
    srir_pkg::srir_rsp_t rsp;
    logic [31:0] w;
    logic [13:0] rel;
    int          slot;
    rsp.read_data = '0;
    slot = int'(r.bus_offset >> 2);
    case (r.mode)
      srir_pkg::MODE_LINE: begin
        if (r.source_index < NUM_SOURCES) begin
          w = source_word[r.source_index];
          if (r.line_level) begin
            if (w[srir_pkg::SRR_BIT]) w[srir_pkg::IOV_BIT] = 1'b1;
            w[srir_pkg::SRR_BIT] = 1'b1;
          end
          source_word[r.source_index] = w;
          rank_targets();
        end
      end
      srir_pkg::MODE_READ: begin
        if (slot < NUM_SOURCES) rsp.read_data = source_word[slot];
      end
      srir_pkg::MODE_WRITE: begin
        if (slot < NUM_SOURCES) begin
          w = r.write_data;
          w[srir_pkg::SETR_BIT] = 1'b0;
          w[srir_pkg::CLRR_BIT] = 1'b0;
          if (r.write_data[srir_pkg::SETR_BIT] && !r.write_data[srir_pkg::CLRR_BIT]) begin
            w[srir_pkg::SRR_BIT] = 1'b1;
          end else if (r.write_data[srir_pkg::CLRR_BIT] &&
                       !r.write_data[srir_pkg::SETR_BIT]) begin
            w[srir_pkg::SRR_BIT] = 1'b0;
          end
          source_word[slot] = w;
          rank_targets();
        end
      end
      srir_pkg::MODE_STATUS: begin
        if (r.bus_offset == srir_pkg::MODULE_ID_OFFSET) begin
          rsp.read_data = srir_pkg::MODULE_ID;
        end else if (r.bus_offset >= srir_pkg::STATUS_BASE &&
                     r.bus_offset < srir_pkg::STATUS_END) begin
          rel = r.bus_offset - srir_pkg::STATUS_BASE;
          if (rel[3:0] == srir_pkg::SUB_STATUS) begin
            rsp.read_data = target_word[rel[6:4]];
          end else if (rel[3:0] == srir_pkg::SUB_ACK) begin
            rsp.read_data = ack_capture;
          end
        end
      end
      srir_pkg::MODE_ACK: begin
        if (r.source_index < NUM_SOURCES) begin
          ack_capture = target_word[r.target_index];
          ack_capture[ENTER_BIT] = 1'b1;
          source_word[r.source_index][srir_pkg::SRR_BIT] = 1'b0;
          rank_targets();
        end
      end
      default: begin
      end
    endcase
    rsp.target_lines = line_mask;
    return rsp;
  endfunction

  always @(posedge clk) begin
    srir_pkg::srir_rsp_t want;
    if (rst) begin
      foreach (source_word[n]) source_word[n] = '0;
      foreach (target_word[t]) target_word[t] = '0;
      ack_capture = '0;
      line_mask = '0;
      expected_rsp.delete();
    end else begin
      if (done) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: result with no request pending: expected none, actual %h %h",
                   $time, result.read_data, result.target_lines);
          failures = failures + 1;
        end else begin
          want = expected_rsp.pop_front();
          if (result.read_data !== want.read_data) begin
            $display("%0t: read_data expected %h actual %h",
                     $time, want.read_data, result.read_data);
            failures = failures + 1;
          end
          if (result.target_lines !== want.target_lines) begin
            $display("%0t: target_lines expected %h actual %h",
                     $time, want.target_lines, result.target_lines);
            failures = failures + 1;
          end
        end
      end
      if (start && !busy) expected_rsp.push_back(serve(request));
    end
    outstanding <= expected_rsp.size();
  end

endmodule

@@ bench/tb_top.sv @@
module tb_top;

  localparam int RANDOM_ITEMS = 1000;
  localparam int CALM_TAIL    = 150;
  localparam int STALL_LIMIT  = 4000;
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  srir_pkg::srir_req_t request = '0;
  logic                busy;
  logic                done;
  srir_pkg::srir_rsp_t result;
  int                  failures;
  int                  outstanding;
  int                  stall_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  service_request_interrupt_router_unit dut (
    .request (request),
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  srir_checker router_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .result      (result),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic srir_pkg::srir_req_t mk(input logic [2:0] mode, input logic [7:0] src,
                                             input logic lvl, input logic [13:0] off,
                                             input logic [31:0] data,
                                             input logic [2:0] tgt);
    srir_pkg::srir_req_t r;
    r.mode = mode;
    r.source_index = src;
    r.line_level = lvl;
    r.bus_offset = off;
    r.write_data = data;
    r.target_index = tgt;
    return r;
  endfunction

  function automatic logic [7:0] pick_source();
    int v;
    v = $urandom_range(0, 15);
    if ($urandom_range(0, 9) < 3) return 8'($urandom);
    return (v < 8) ? 8'(v) : 8'(v + 240);
  endfunction

  function automatic logic [31:0] word_data();
    logic [31:0] d;
    d = $urandom;
    d[srir_pkg::SRE_BIT] = ($urandom_range(0, 4) != 0);
    case ($urandom_range(0, 3))
      0: d[7:0] = 8'hFF;
      1: d[7:0] = 8'h00;
      default: d[7:0] = 8'($urandom_range(1, 3));
    endcase
    return d;
  endfunction

  function automatic srir_pkg::srir_req_t random_request();
    srir_pkg::srir_req_t r;
    int                  pick;
    r.mode = srir_pkg::MODE_LINE;
    r.source_index = pick_source();
    r.line_level = ($urandom_range(0, 3) != 0);
    r.bus_offset = 14'($urandom);
    r.write_data = $urandom;
    r.target_index = 3'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      r.mode = srir_pkg::MODE_LINE;
    end else if (pick < 50) begin
      r.mode = srir_pkg::MODE_WRITE;
      r.write_data = word_data();
      if ($urandom_range(0, 9) != 0) r.bus_offset = {4'b0000, pick_source(), 2'($urandom)};
    end else if (pick < 65) begin
      r.mode = srir_pkg::MODE_ACK;
    end else if (pick < 80) begin
      r.mode = srir_pkg::MODE_READ;
      if ($urandom_range(0, 9) != 0) r.bus_offset = {4'b0000, pick_source(), 2'($urandom)};
    end else if (pick < 95) begin
      r.mode = srir_pkg::MODE_STATUS;
      case ($urandom_range(0, 5))
        0: r.bus_offset = srir_pkg::MODULE_ID_OFFSET;
        5: r.bus_offset = 14'($urandom);
        default: r.bus_offset = srir_pkg::STATUS_BASE +
                   14'($urandom_range(0, 7) * 16 + $urandom_range(0, 3) * 4);
      endcase
    end else begin
      r.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    end
    return r;
  endfunction

  task automatic issue(input srir_pkg::srir_req_t r);
    request <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic rest(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    srir_pkg::srir_req_t plan [$];
    plan.push_back(mk(srir_pkg::MODE_STATUS,
                      8'h00, 1'b0, srir_pkg::MODULE_ID_OFFSET, 32'h0, 3'd0));
    plan.push_back(mk(srir_pkg::MODE_STATUS,
                      8'h00, 1'b0, srir_pkg::STATUS_BASE, 32'h0, 3'd0));
    plan.push_back(mk(srir_pkg::MODE_READ, 8'h00, 1'b0, 14'h0003, 32'h0, 3'd0));
    plan.push_back(mk(srir_pkg::MODE_WRITE, 8'h00, 1'b0, 14'h0000, 32'h0400_3CFF, 3'd0));
    plan.push_back(mk(srir_pkg::MODE_WRITE, 8'hFF, 1'b1, 14'h03FC, 32'h0700_3CFF, 3'd7));
    plan.push_back(mk(srir_pkg::MODE_STATUS,
                      8'h00, 1'b0, srir_pkg::STATUS_BASE + 14'h0070, 32'h0, 3'd0));
    plan.push_back(mk(srir_pkg::MODE_LINE, 8'h00, 1'b1, 14'h0000, 32'h0, 3'd0));
    plan.push_back(mk(srir_pkg::MODE_LINE, 8'h05, 1'b1, 14'h0000, 32'h0, 3'd0));
    plan.push_back(mk(srir_pkg::MODE_LINE, 8'h05, 1'b1, 14'h0000, 32'h0, 3'd0));
    plan.push_back(mk(srir_pkg::MODE_LINE, 8'h03, 1'b0, 14'h3FFF, 32'hFFFF_FFFF, 3'd7));
    plan.push_back(mk(srir_pkg::MODE_READ, 8'h00, 1'b0, 14'h0000, 32'h0, 3'd0));
    plan.push_back(mk(srir_pkg::MODE_ACK, 8'hFF, 1'b0, 14'h0000, 32'h0, 3'd7));
    plan.push_back(mk(srir_pkg::MODE_STATUS,
                      8'h00, 1'b0, srir_pkg::STATUS_BASE + 14'h0004, 32'h0, 3'd0));
    plan.push_back(mk(srir_pkg::MODE_WRITE, 8'h00, 1'b0, 14'h0000, 32'h0200_3CFF, 3'd0));
    plan.push_back(mk(srir_pkg::MODE_WRITE, 8'h01, 1'b0, 14'h0004, 32'hFFFF_FFFF, 3'd0));
    plan.push_back(mk(srir_pkg::MODE_READ, 8'h00, 1'b0, 14'h03FC, 32'h0, 3'd0));
    plan.push_back(mk(srir_pkg::MODE_WRITE, 8'h00, 1'b0, 14'h3FFF, 32'hFFFF_FFFF, 3'd0));
    plan.push_back(mk(srir_pkg::MODE_READ, 8'h00, 1'b0, 14'h0400, 32'h0, 3'd0));
    plan.push_back(mk(srir_pkg::MODE_STATUS, 8'h00, 1'b0, 14'h3FFF, 32'h0, 3'd0));
    plan.push_back(mk(srir_pkg::MODE_STATUS,
                      8'h00, 1'b0, srir_pkg::STATUS_BASE + 14'h000C, 32'h0, 3'd0));
    plan.push_back(mk(srir_pkg::MODE_STATUS,
                      8'h00, 1'b0, srir_pkg::STATUS_END - 14'h0004, 32'h0, 3'd0));
    plan.push_back(mk(MODE_SPARE_LO, 8'hFF, 1'b1, 14'h3FFF, 32'hFFFF_FFFF, 3'd7));
    plan.push_back(mk(MODE_SPARE_HI, 8'hFF, 1'b1, 14'h0008, 32'hFFFF_FFFF, 3'd7));
    plan.push_back(mk(srir_pkg::MODE_WRITE, 8'h00, 1'b0, 14'h0005, 32'h0000_0000, 3'd0));
    plan.push_back(mk(srir_pkg::MODE_ACK, 8'h00, 1'b0, 14'h0000, 32'h0, 3'd0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) issue(plan[i]);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      issue(random_request());
      if (i < RANDOM_ITEMS - CALM_TAIL && (i / 50) % 2 == 0 && $urandom_range(0, 3) == 0) begin
        rest($urandom_range(1, 5));
      end
    end
    start <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (failures == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
